>>> rtl/core/kcl_pkg.sv
package kcl_pkg;

   localparam int LOCK_W    = 20;
   localparam int TRIES_W   = 4;
   localparam int DIGIT_W   = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 20;

   localparam logic [7:0] KEY_HASH = 8'h23;
   localparam logic [7:0] KEY_STAR = 8'h2A;
   localparam logic [7:0] KEY_0    = 8'h30;
   localparam logic [7:0] KEY_9    = 8'h39;

   localparam logic [LOCK_W-1:0]  LOCKOUT_RESET   = 20'd30000;
   localparam logic [TRIES_W-1:0] MAX_WRONG_RESET = 4'd3;
   localparam logic [TRIES_W-1:0] WRONG_SAT       = 4'd15;

   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_TICKS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT   = 1'b1;

   localparam logic [1:0] BEEPS_NONE   = 2'd0;
   localparam logic [1:0] BEEPS_DENIED = 2'd1;
   localparam logic [1:0] BEEPS_LOCKED = 2'd3;

   typedef enum logic [1:0] {
      CMD_KEY    = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_CHANGE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_VERIFY  = 2'd0,
      PH_CHG_OLD = 2'd1,
      PH_NEW     = 2'd2,
      PH_CONFIRM = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE         = 4'd0,
      EV_DIGIT        = 4'd1,
      EV_ERASE        = 4'd2,
      EV_GRANTED      = 4'd3,
      EV_DENIED       = 4'd4,
      EV_LOCKED       = 4'd5,
      EV_UNLOCKED     = 4'd6,
      EV_NEW_TAKEN    = 4'd7,
      EV_CHANGED      = 4'd8,
      EV_MISMATCH     = 4'd9,
      EV_CHANGE_BEGUN = 4'd10
   } event_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] key_code;
   } req_word_type;

   typedef struct packed {
      logic [3:0] event_res;
      logic [2:0] entered_count;
      logic [3:0] failures;
      logic       locked;
      logic [1:0] beeps;
      logic [1:0] phase;
   } rsp_word_type;

   typedef struct packed {
      logic [LOCK_W-1:0]  lockout_ticks;
      logic [TRIES_W-1:0] retry_limit;
   } cfg_type;

endpackage

>>> rtl/core/kcl_engine.sv
module kcl_engine #(
   parameter int CODE_DIGITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  kcl_pkg::req_word_type item,
   input  kcl_pkg::cfg_type      cfg,
   output kcl_pkg::rsp_word_type result
);
   import kcl_pkg::*;

   localparam int CNT_W = $clog2(CODE_DIGITS + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(CODE_DIGITS);

   logic [CODE_DIGITS-1:0][DIGIT_W-1:0] stored_ff;
   logic [CODE_DIGITS-1:0][DIGIT_W-1:0] entry_ff;
   logic [CODE_DIGITS-1:0][DIGIT_W-1:0] new_code_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TRIES_W-1:0] wrong_ff, wrong_in, wrong_sat;
   phase_type          phase_ff, phase_in;
   logic [LOCK_W-1:0]  lock_ff, lock_in;

   logic               locked_now;
   logic               digit_wr;
   logic [DIGIT_W-1:0] digit_val;
   logic               copy_new;
   logic               store_code;
   event_type          ev;
   logic [1:0]         beeps;

   always_comb begin
      locked_now = (lock_ff != '0);
      wrong_sat  = (wrong_ff == WRONG_SAT) ? wrong_ff : wrong_ff + 4'd1;
      digit_val  = DIGIT_W'(item.key_code - KEY_0);
      count_in   = count_ff;
      wrong_in   = wrong_ff;
      phase_in   = phase_ff;
      lock_in    = lock_ff;
      digit_wr   = 1'b0;
      copy_new   = 1'b0;
      store_code = 1'b0;
      ev         = EV_NONE;
      beeps      = BEEPS_NONE;
      case (item.cmd)
         CMD_TICK: begin
            if (locked_now) begin
               lock_in = lock_ff - LOCK_W'(1);
               if (lock_ff == LOCK_W'(1)) begin
                  wrong_in = '0;
                  ev       = EV_UNLOCKED;
               end
            end
         end
         CMD_CHANGE: begin
            if (!locked_now) begin
               phase_in = PH_CHG_OLD;
               count_in = '0;
               ev       = EV_CHANGE_BEGUN;
            end
         end
         CMD_KEY: begin
            if (!locked_now) begin
               if (item.key_code == KEY_HASH) begin
                  if (count_ff == FULL) begin
                     count_in = '0;
                     case (phase_ff)
                        PH_NEW: begin
                           copy_new = 1'b1;
                           phase_in = PH_CONFIRM;
                           ev       = EV_NEW_TAKEN;
                        end
                        PH_CONFIRM: begin
                           if (entry_ff == new_code_ff) begin
                              store_code = 1'b1;
                              phase_in   = PH_VERIFY;
                              ev         = EV_CHANGED;
                           end else begin
                              phase_in = PH_NEW;
                              ev       = EV_MISMATCH;
                           end
                        end
                        default: begin
                           if (entry_ff == stored_ff) begin
                              wrong_in = '0;
                              if (phase_ff == PH_CHG_OLD) begin
                                 phase_in = PH_NEW;
                              end
                              ev = EV_GRANTED;
                           end else begin
                              phase_in = PH_VERIFY;
                              if (wrong_sat >= cfg.retry_limit) begin
                                 lock_in  = cfg.lockout_ticks;
                                 wrong_in = (cfg.lockout_ticks == '0) ? '0 : wrong_sat;
                                 beeps    = BEEPS_LOCKED;
                                 ev       = EV_LOCKED;
                              end else begin
                                 wrong_in = wrong_sat;
                                 beeps    = BEEPS_DENIED;
                                 ev       = EV_DENIED;
                              end
                           end
                        end
                     endcase
                  end
               end else if (item.key_code == KEY_STAR) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - CNT_W'(1);
                     ev       = EV_ERASE;
                  end
               end else if (item.key_code inside {[KEY_0:KEY_9]}) begin
                  if (count_ff < FULL) begin
                     digit_wr = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     ev       = EV_DIGIT;
                  end
               end
            end
         end
         default: begin
            ev = EV_NONE;
         end
      endcase

      result.event_res     = ev;
      result.entered_count = 3'(count_in);
      result.failures      = wrong_in;
      result.locked        = (lock_in != '0);
      result.beeps         = beeps;
      result.phase         = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wrong_ff <= '0;
         phase_ff <= PH_VERIFY;
         lock_ff  <= '0;
         for (int i = 0; i < CODE_DIGITS; i++) begin
            stored_ff[i] <= DIGIT_W'(i + 1);
         end
      end else if (fire) begin
         count_ff <= count_in;
         wrong_ff <= wrong_in;
         phase_ff <= phase_in;
         lock_ff  <= lock_in;
         if (store_code) begin
            stored_ff <= new_code_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && copy_new) begin
         new_code_ff <= entry_ff;
      end
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if (fire && digit_wr && count_ff == CNT_W'(i)) begin
            entry_ff[i] <= digit_val;
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count beyond the code length");

   a_unlock_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.cmd == CMD_TICK && lock_ff == LOCK_W'(1) |=> wrong_ff == '0 && lock_ff == '0)
      else $error("end of lockout did not clear the failure count");

   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      lock_ff != '0 && !(fire && item.cmd == CMD_TICK) |=> $stable(lock_ff))
      else $error("lockout counter moved without a tick");

   a_locked_phase: assert property (@(posedge clock) disable iff (reset)
      lock_ff != '0 |-> phase_ff == PH_VERIFY)
      else $error("lockout running outside the verify phase");

endmodule

>>> rtl/core/keypad_code_lock.sv
// Keypad code lock with wrong-entry lockout. Each request word is a key press, a 1 ms tick, a
// request to begin a code change or a no-op, and yields exactly one response word carrying the
// event, the digit count, the failure count, the lock flag, the beep count and the flow phase.
// The block takes one request word per clock cycle while the response side does not stall; a
// word waits in the input register until it advances, which registers its response. The lock
// state, the entry and both codes are updated on that advance by the code compare and sequencing
// logic between the two registers, which sets the one-word-per-cycle rate. The user must write
// registers through the csr port only while no word is in flight; the block does not enforce it.
module keypad_code_lock #(
   parameter int CODE_DIGITS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kcl_pkg::req_word_type              req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kcl_pkg::rsp_word_type              rsp_word,
   input  logic                               csr_write,
   input  logic [kcl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kcl_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import kcl_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;
   cfg_type      cfg_ff;
   rsp_word_type result;
   logic         advance;
   logic         accept;

   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lockout_ticks <= LOCKOUT_RESET;
         cfg_ff.retry_limit   <= MAX_WRONG_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOCKOUT_TICKS: cfg_ff.lockout_ticks <= csr_wdata;
            CSR_RETRY_LIMIT:   cfg_ff.retry_limit   <= TRIES_W'(csr_wdata);
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   kcl_engine #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_word_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   a_advance_delivers: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_word_ff == $past(result))
      else $error("processed word did not reach the response register");

endmodule
